/* sv/modbus_rtu_request_framer_top_assert.svh */
// ----------------------------------------------------------------------------
// modbus rtu request framer assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset aware
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define MRF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modbus framer assertion failed");

// next-cycle implication
`define MRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus framer assertion failed");

`endif

/* sv/mrf_pkg.sv */
// ----------------------------------------------------------------------------
// mrf_pkg
// types, constants and crc helpers for the modbus rtu request framer
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int HDR_LEN   = 6;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [17:0] RESP_BASE = 18'd5;

    typedef logic [2:0] byte_idx_t;

    // frame byte positions
    localparam byte_idx_t BYTE_SLAVE   = 3'd0;
    localparam byte_idx_t BYTE_FUNC    = 3'd1;
    localparam byte_idx_t BYTE_ADDR_HI = 3'd2;
    localparam byte_idx_t BYTE_ADDR_LO = 3'd3;
    localparam byte_idx_t BYTE_QTY_HI  = 3'd4;
    localparam byte_idx_t BYTE_QTY_LO  = 3'd5;
    localparam byte_idx_t BYTE_CRC_LO  = 3'd6;
    localparam byte_idx_t BYTE_CRC_HI  = 3'd7;

    // register map
    localparam logic [0:0] REG_SLAVE_ADDRESS = 1'b0;

    typedef struct packed {
        logic [7:0]  slave;
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [17:0] resp_len;
    } req_t;

    typedef struct packed {
        req_t        req;
        logic [15:0] crc;
    } frame_t;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // header bytes, crc bytes read as zero
    function automatic logic [7:0] hdr_byte(input req_t r, input byte_idx_t k);
        logic [7:0] b;
        unique case (k)
            BYTE_SLAVE:   b = r.slave;
            BYTE_FUNC:    b = r.fc;
            BYTE_ADDR_HI: b = r.addr[15:8];
            BYTE_ADDR_LO: b = r.addr[7:0];
            BYTE_QTY_HI:  b = r.qty[15:8];
            BYTE_QTY_LO:  b = r.qty[7:0];
            default:      b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] frame_byte_sel(input frame_t f, input byte_idx_t k);
        logic [7:0] b;
        unique case (k)
            BYTE_CRC_LO: b = f.crc[7:0];
            BYTE_CRC_HI: b = f.crc[15:8];
            default:     b = hdr_byte(f.req, k);
        endcase
        return b;
    endfunction

endpackage

/* sv/mrf_crc_pipe.sv */
// ----------------------------------------------------------------------------
// mrf_crc_pipe
// six-stage crc pipeline, one header byte folded into the crc per stage
// ----------------------------------------------------------------------------
module mrf_crc_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mrf_pkg::req_t   in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output mrf_pkg::frame_t out_frame
);
    import mrf_pkg::*;

    logic   [HDR_LEN-1:0] valid_reg;
    logic   [HDR_LEN-1:0] stage_ready;
    logic   [HDR_LEN-1:0] up_valid;
    frame_t               stage_reg  [HDR_LEN];
    frame_t               stage_next [HDR_LEN];

    // stage k is fed by stage k-1, stage 0 by the input channel
    assign up_valid = {valid_reg[HDR_LEN-2:0], in_valid};

    // a stage moves when empty or when its successor takes its item
    always_comb
    begin
        stage_ready[HDR_LEN-1] = !valid_reg[HDR_LEN-1] || out_ready;
        for (int k = HDR_LEN - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        stage_next[0].req = in_req;
        stage_next[0].crc = crc_byte(CRC_INIT, in_req.slave);
        for (int k = 1; k < HDR_LEN; k++) begin
            stage_next[k].req = stage_reg[k-1].req;
            stage_next[k].crc = crc_byte(stage_reg[k-1].crc,
                                         hdr_byte(stage_reg[k-1].req, byte_idx_t'(k)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < HDR_LEN; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= up_valid[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < HDR_LEN; k++) begin
            if (stage_ready[k] && up_valid[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[HDR_LEN-1];
    assign out_frame = stage_reg[HDR_LEN-1];

endmodule

/* sv/modbus_rtu_request_framer_top.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_top
// builds the eight-byte modbus rtu read request frame with crc-16, one byte
// per output item
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------
//  input     | in        | in_valid/in_ready  | func_code, start_address, quantity
//  output    | out       | out_valid/out_ready| frame_byte, last_byte, response_length
//  config    | in        | apb psel/penable   | slave_address at byte address 0
//
//  a request enters a six-stage crc pipeline (one frame byte folded in per stage)
//  and reaches the byte serializer after passing through every stage
//  the serializer emits eight output items per request, one per cycle while
//  out_ready is high; the pipeline buffers up to six requests, accepting one per
//  cycle until full
//  reset empties the pipeline and serializer and sets the slave address to 1
//  out_ready low holds the current byte; the backpressure ripples into the
//  pipeline and drops in_ready only once every stage holds an item
//
module modbus_rtu_request_framer_top (
    input  logic        clk,
    input  logic        rst_n,
    // request input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  func_code,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    // frame byte output
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic [17:0] response_length,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrf_pkg::*;

`include "modbus_rtu_request_framer_top_assert.svh"

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [7:0] slave_reg;
    logic [0:0] reg_index;
    logic       cfg_write;

    assign reg_index = paddr[2:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_reg <= 8'd1;
        end else if (cfg_write && (reg_index == REG_SLAVE_ADDRESS)) begin
            slave_reg <= pwdata[7:0];
        end
    end

    // unmapped addresses read as zero
    always_comb
    begin
        prdata = 32'h0;
        if (reg_index == REG_SLAVE_ADDRESS) begin
            prdata = {24'h0, slave_reg};
        end
    end

    // ------------------------------------------------------------------
    // request capture and crc pipeline
    // ------------------------------------------------------------------
    req_t   in_req;
    frame_t pipe_frame;
    logic   pipe_valid;
    logic   pipe_ready;

    always_comb
    begin
        in_req.slave    = slave_reg;
        in_req.fc       = func_code;
        in_req.addr     = start_address;
        in_req.qty      = quantity;
        // twice the quantity plus the five fixed reply bytes, never wraps at 18 bits
        in_req.resp_len = {1'b0, quantity, 1'b0} + RESP_BASE;
    end

    mrf_crc_pipe u_crc_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_frame (pipe_frame)
    );

    // ------------------------------------------------------------------
    // byte serializer
    // ------------------------------------------------------------------
    logic      busy_reg, busy_next;
    byte_idx_t cnt_reg, cnt_next;
    frame_t    frame_reg;
    logic      out_take;
    logic      at_last;

    assign at_last    = (cnt_reg == BYTE_CRC_HI);
    assign out_take   = busy_reg && out_ready;
    // a new frame loads while idle or as the crc high byte leaves
    assign pipe_ready = !busy_reg || (out_ready && at_last);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        priority if (pipe_ready && pipe_valid) begin
            busy_next = 1'b1;
            cnt_next  = BYTE_SLAVE;
        end else if (out_take) begin
            busy_next = !at_last;
            cnt_next  = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= BYTE_SLAVE;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_ready && pipe_valid) begin
            frame_reg <= pipe_frame;
        end
    end

    assign out_valid       = busy_reg;
    assign frame_byte      = frame_byte_sel(frame_reg, cnt_reg);
    assign last_byte       = at_last;
    assign response_length = frame_reg.req.resp_len;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MRF_ASSERT_NEXT(a_mid_advance, clk, rst_n, out_valid && out_ready && !last_byte,
                     out_valid && (cnt_reg == 3'($past(cnt_reg) + 3'd1)))
    `MRF_ASSERT_NEXT(a_last_wraps, clk, rst_n, out_valid && out_ready && last_byte,
                     !out_valid || (cnt_reg == BYTE_SLAVE))
    `MRF_ASSERT_SAME(a_len_odd, clk, rst_n, out_valid, response_length[0])
    `MRF_ASSERT_SAME(a_no_load_busy, clk, rst_n, busy_reg && !(out_ready && at_last),
                     !pipe_ready)

endmodule

/* tb/sv/modbus_rtu_request_framer_checker.sv */
// ----------------------------------------------------------------------------
// modbus rtu request framer checker
// watches the request, frame byte and apb channels, rebuilds every request
// frame with its own crc-16 and compares each output item in order
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  func_code,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    input  logic [17:0] response_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] MODBUS_CRC_SEED = 16'hFFFF;
    localparam logic [15:0] MODBUS_CRC_POLY = 16'hA001;
    localparam logic [17:0] REPLY_OVERHEAD  = 18'd5;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [17:0] reply_len;
    } frame_item_t;

    frame_item_t expected_bytes[$];
    logic [7:0]  slave_addr_shadow;

    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ MODBUS_CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // eight frame bytes of one request, crc low byte before high byte
    function automatic void queue_request_frame(input logic [7:0] fc, input logic [15:0] addr,
                                                input logic [15:0] qty);
        logic [7:0]  bytes [mrf_pkg::FRAME_LEN];
        logic [15:0] crc;
        frame_item_t item;
        bytes[0] = slave_addr_shadow;
        bytes[1] = fc;
        bytes[2] = addr[15:8];
        bytes[3] = addr[7:0];
        bytes[4] = qty[15:8];
        bytes[5] = qty[7:0];
        crc = MODBUS_CRC_SEED;
        for (int k = 0; k < mrf_pkg::HDR_LEN; k++) begin
            crc = crc16_fold(crc, bytes[k]);
        end
        bytes[6] = crc[7:0];
        bytes[7] = crc[15:8];
        for (int k = 0; k < mrf_pkg::FRAME_LEN; k++) begin
            item.data      = bytes[k];
            item.last      = (k == mrf_pkg::FRAME_LEN - 1);
            item.reply_len = {1'b0, qty, 1'b0} + REPLY_OVERHEAD;
            expected_bytes.insert(expected_bytes.size(), item);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frame_item_t want;
        if (!rst_n) begin
            slave_addr_shadow = 8'd1;
            expected_bytes.delete();
            errors  = 0;
            pending <= 0;
        end else begin
            // register reads and writes, unmapped addresses are ignored
            if (psel && penable && pready && (paddr >> 2) == mrf_pkg::REG_SLAVE_ADDRESS) begin
                if (pwrite) begin
                    slave_addr_shadow = pwdata[7:0];
                end else if (prdata !== {24'd0, slave_addr_shadow}) begin
                    $display("%0t: slave address readback, expected %08h actual %08h",
                             $time, {24'd0, slave_addr_shadow}, prdata);
                    errors++;
                end
            end
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected frame byte, expected none actual %02h",
                             $time, frame_byte);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (frame_byte !== want.data) begin
                        $display("%0t: frame_byte, expected %02h actual %02h",
                                 $time, want.data, frame_byte);
                        errors++;
                    end
                    if (last_byte !== want.last) begin
                        $display("%0t: last_byte, expected %0b actual %0b",
                                 $time, want.last, last_byte);
                        errors++;
                    end
                    if (response_length !== want.reply_len) begin
                        $display("%0t: response_length, expected %0d actual %0d",
                                 $time, want.reply_len, response_length);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                queue_request_frame(func_code, start_address, quantity);
            end
            pending <= expected_bytes.size();
        end
    end

endmodule

/* tb/sv/modbus_rtu_request_framer_top_tb.sv */
// ----------------------------------------------------------------------------
// modbus rtu request framer testbench
// directed and random read requests under several slave address settings and
// idle patterns, with a checker that predicts every frame byte
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // register byte addresses
    localparam logic [2:0] ADDR_SLAVE_ADDRESS = 3'(4 * mrf_pkg::REG_SLAVE_ADDRESS);
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

    // generous bound on the length of a correct run
    localparam int CYCLE_LIMIT    = 200000;
    // covers the six pipeline stages plus a frame of serializer output
    localparam int SETTLE_CYCLES  = 16;
    localparam int ITEMS_PER_PHASE = 42;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  func_code = 8'h00;
    logic [15:0] start_address = 16'h0000;
    logic [15:0] quantity = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [17:0] response_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycle_count = 0;

    // percentage of cycles the request side sits idle and the sink stalls
    int send_idle_pct = 0;
    int out_stall_pct = 0;

    // 50 MHz clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    modbus_rtu_request_framer_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func_code       (func_code),
        .start_address   (start_address),
        .quantity        (quantity),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte),
        .response_length (response_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // predicts and compares every frame byte, counts mismatches
    modbus_rtu_request_framer_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func_code       (func_code),
        .start_address   (start_address),
        .quantity        (quantity),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_byte      (frame_byte),
        .last_byte       (last_byte),
        .response_length (response_length),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .errors          (errors),
        .pending         (pending)
    );

    // watchdog, a stuck handshake or a missing frame byte ends up here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** modbus_rtu_request_framer_top: FAILED **");
            $finish;
        end
    end

    // frame byte sink, stalls at random in the phases that ask for it
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // one apb transfer, setup then access, then the bus released before returning
    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // hands one request item over, with random idle cycles in front of it
    task automatic send_request(input logic [7:0] fc, input logic [15:0] addr,
                                input logic [15:0] qty);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func_code     <= fc;
        start_address <= addr;
        quantity      <= qty;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // mostly plausible read requests, with extremes and full-range noise
    task automatic send_random_request();
        logic [7:0]  fc;
        logic [15:0] addr;
        logic [15:0] qty;
        case ($urandom_range(4))
            0, 1:    fc = 8'($urandom_range(1, 4));
            2:       fc = $urandom_range(1) ? 8'hFF : 8'h00;
            default: fc = 8'($urandom);
        endcase
        case ($urandom_range(9))
            0:       addr = 16'h0000;
            1:       addr = 16'hFFFF;
            default: addr = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       qty = 16'h0000;
            1:       qty = 16'hFFFF;
            2, 3:    qty = 16'($urandom);
            default: qty = 16'($urandom_range(1, 125));
        endcase
        send_request(fc, addr, qty);
    endtask

    // release the request channel and wait until every frame byte is out,
    // pending is registered behind the handshake so look only in the following cycle
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slave address comes out of reset as 1
        apb_access(1'b0, ADDR_SLAVE_ADDRESS, 32'd0);

        // directed part, no idling
        send_request(8'h03, 16'h0000, 16'h000A);    // textbook frame, crc cd c5
        send_request(8'h00, 16'h0000, 16'h0000);    // zero quantity, reply length 5
        send_request(8'hFF, 16'hFFFF, 16'hFFFF);    // largest reply length, no wrap
        send_request(8'h04, 16'h00FF, 16'hFF00);
        send_request(8'h01, 16'hAAAA, 16'h5555);
        send_request(8'h02, 16'h5555, 16'hAAAA);
        send_request(8'hAA, 16'h8000, 16'h0001);
        send_request(8'h55, 16'h0001, 16'h8000);
        send_request(8'h80, 16'h1234, 16'h007D);    // largest legal read count
        send_request(8'h7F, 16'hFEDC, 16'h7FFF);
        send_request(8'h10, 16'h0000, 16'h0001);    // write code framed as is
        send_request(8'h2B, 16'hFFFF, 16'h0000);
        drain_frames();

        for (int phase = 0; phase < 4; phase++) begin
            // new slave address while idle, then read it back
            case (phase)
                0:       apb_access(1'b1, ADDR_SLAVE_ADDRESS, 32'h0000_0000);
                1:       apb_access(1'b1, ADDR_SLAVE_ADDRESS, 32'h0000_00FF);
                2:       apb_access(1'b1, ADDR_SLAVE_ADDRESS, 32'hFFFF_FF00 | $urandom_range(255));
                default: apb_access(1'b1, ADDR_SLAVE_ADDRESS, $urandom);
            endcase
            // unmapped register, must leave the slave address alone
            if (phase >= 2) begin
                apb_access(1'b1, ADDR_UNMAPPED, $urandom);
            end
            apb_access(1'b0, ADDR_SLAVE_ADDRESS, 32'd0);

            case (phase)
                0:       begin send_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; out_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  out_stall_pct = 51; end
                default: begin send_idle_pct = 36; out_stall_pct = 36; end
            endcase

            repeat (ITEMS_PER_PHASE) send_random_request();
            drain_frames();
        end

        if (errors == 0) begin
            $display("** modbus_rtu_request_framer_top: PASSED **");
        end else begin
            $display("** modbus_rtu_request_framer_top: FAILED **");
        end
        $finish;
    end

endmodule
